// ===== rtl/rhh_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Robin Hood hash table package
// Shared sizes, status codes, operation codes and controller states.
// ---------------------------------------------------------------------------
package rhh_pkg;
	localparam int CAPACITY   = 1024;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int HASH_W     = 64;
	localparam int MAXE_W     = 11;
	localparam int PROBE_W    = 11;
	localparam logic [MAXE_W-1:0] MAXE_RESET = MAXE_W'(768);

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_LOOKUP = 2'd1,
		FN_REMOVE = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXISTS    = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_INS_RD,
		S_INS_CHK,
		S_DEL_RD,
		S_DEL_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [HASH_W-1:0]     hash;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	// probe distance of a slot holding an entry with the given hash
	function automatic logic [IDX_W-1:0] dist_of(input logic [IDX_W-1:0] idx,
		input logic [HASH_W-1:0] h);
		dist_of = idx - h[IDX_W-1:0];
	endfunction
endpackage

// ===== rtl/robin_hood_hash_table_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Robin Hood hash table core
// Key/value table with Robin Hood insert and backward-shift remove.
// ---------------------------------------------------------------------------
// One operation at a time. Each step of the search, insert or shift pass
//   reads a slot and, in the next state, decides on the registered data
//   and writes back through the separate write port.
// Reset clears the live count and loads max_entries with 768; a clearing pass
//   then empties all 1024 slots of the occupancy memory with busy held high.
// The result strobe (done) is high for one cycle; the receiver cannot stall.
module robin_hood_hash_table_core import rhh_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             func,
	input  logic [63:0]            key_in,
	input  logic [63:0]            key_hash,
	input  logic [63:0]            value_in,
	output logic                   done,
	output logic [1:0]             status,
	output logic [63:0]            read_value,
	output logic [PROBE_W-1:0]     probe_length,
	output logic [CNT_W-1:0]       entry_count,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	// slot payload memory (hash, key, value), one sync read port, one write
	entry_t              mem [CAPACITY];
	entry_t              rd_q;
	// occupancy memory, emptied by the clearing pass after reset
	logic                occ_mem [CAPACITY];

	state_t              st_q, st_d;
	logic [1:0]          func_q;
	entry_t              req_q;       // request word, later the carried entry
	logic [IDX_W-1:0]    idx_q;       // current slot
	logic [IDX_W-1:0]    hole_q;      // remove: slot to refill
	logic [PROBE_W-1:0]  step_q;      // slots examined so far, shift count on remove
	logic [IDX_W:0]      cdist_q;     // insert: carried probe distance
	logic                rd_occ_q;    // occupancy of the slot read
	logic [CNT_W-1:0]    live_q;
	logic [MAXE_W-1:0]   maxe_q;
	logic [1:0]          stat_q;
	logic [63:0]         rval_q;
	logic [PROBE_W-1:0]  probe_q;
	logic                done_q;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	entry_t              mem_wd;
	logic                occ_we;
	logic [IDX_W-1:0]    occ_wa;
	logic                occ_wd;
	logic                hit, poorer, swap, del_end;
	logic [IDX_W-1:0]    their;
	logic [IDX_W-1:0]    nxt_idx;

	// configuration port: single register at address 0
	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr == 3'd0) begin
			prdata = 32'(maxe_q);
		end
	end

	assign their   = dist_of(idx_q, rd_q.hash);
	assign hit     = rd_occ_q && rd_q.hash == req_q.hash && rd_q.key == req_q.key;
	// stop the search when the resident is closer to home than our distance
	assign poorer  = 32'(their) < 32'(step_q) - 32'd1;
	assign swap    = cdist_q > {1'b0, their};
	assign nxt_idx = idx_q + 1'b1;
	// end the shift on an empty or home slot, or once the whole ring is walked
	assign del_end = !rd_occ_q || their == '0 || step_q == PROBE_W'(CAPACITY - 1);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_CLEAR: begin
				st_d = (idx_q == '1) ? S_IDLE : S_CLEAR;
			end
			S_IDLE: begin
				if (start) begin
					st_d = (func == FN_NONE) ? S_DONE : S_SRCH_RD;
				end
			end
			S_SRCH_RD:  st_d = S_SRCH_CHK;
			S_SRCH_CHK: begin
				priority if (hit) begin
					st_d = (func_q == FN_REMOVE) ? S_DEL_RD : S_DONE;
				end else if (!rd_occ_q || poorer || step_q == PROBE_W'(CAPACITY)) begin
					if (func_q == FN_INSERT && 32'(live_q) < 32'(maxe_q)
						&& 32'(live_q) < CAPACITY) begin
						st_d = S_INS_RD;
					end else begin
						st_d = S_DONE;
					end
				end else begin
					st_d = S_SRCH_RD;
				end
			end
			S_INS_RD:  st_d = S_INS_CHK;
			S_INS_CHK: st_d = rd_occ_q ? S_INS_RD : S_DONE;
			S_DEL_RD:  st_d = S_DEL_CHK;
			S_DEL_CHK: begin
				st_d = del_end ? S_DONE : S_DEL_RD;
			end
			S_DONE:    st_d = S_IDLE;
			default:   st_d = S_IDLE;
		endcase
	end

	// memory write decode
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = req_q;
		occ_we = 1'b0;
		occ_wa = idx_q;
		occ_wd = 1'b0;
		unique case (st_q)
			S_CLEAR: occ_we = 1'b1;
			S_INS_CHK: begin
				mem_we = !rd_occ_q || swap;
				occ_we = !rd_occ_q;
				occ_wd = 1'b1;
			end
			S_DEL_CHK: begin
				mem_we = rd_occ_q && their != '0;
				mem_wa = hole_q;
				mem_wd = rd_q;
				// drop the last slot of the shifted run
				occ_we = del_end;
				occ_wa = (rd_occ_q && their != '0) ? idx_q : hole_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (occ_we) begin
			occ_mem[occ_wa] <= occ_wd;
		end
		rd_q     <= mem[idx_q];
		rd_occ_q <= occ_mem[idx_q];
	end

	assign busy = st_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLEAR;
			idx_q    <= '0;
			live_q   <= '0;
			maxe_q   <= MAXE_RESET;
			done_q   <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= 1'b0;
			if (psel && penable && pwrite && paddr == 3'd0) begin
				maxe_q <= pwdata[MAXE_W-1:0];
			end
			unique case (st_q)
				S_CLEAR: idx_q <= nxt_idx;
				S_IDLE: begin
					if (start) begin
						func_q       <= func;
						req_q.key    <= key_in[KEY_BITS-1:0];
						req_q.hash   <= key_hash;
						req_q.value  <= value_in[VALUE_BITS-1:0];
						idx_q        <= key_hash[IDX_W-1:0];
						step_q       <= PROBE_W'(1);
						cdist_q      <= '0;
						stat_q       <= ST_NOT_FOUND;
						rval_q       <= '0;
						probe_q      <= '0;
					end
				end
				S_SRCH_CHK: begin
					probe_q <= step_q;
					priority if (hit) begin
						unique case (func_q)
							FN_INSERT: stat_q <= ST_EXISTS;
							FN_LOOKUP: begin
								stat_q <= ST_OK;
								rval_q <= 64'(rd_q.value);
							end
							default: begin
								stat_q <= ST_OK;
								hole_q <= idx_q;
								idx_q  <= nxt_idx;
								step_q <= PROBE_W'(1);
							end
						endcase
					end else if (!rd_occ_q || poorer || step_q == PROBE_W'(CAPACITY)) begin
						// miss: restart from home for insert
						idx_q  <= req_q.hash[IDX_W-1:0];
						step_q <= PROBE_W'(1);
						if (func_q == FN_INSERT) begin
							stat_q <= ST_FULL;
						end
					end else begin
						idx_q  <= nxt_idx;
						step_q <= step_q + 1'b1;
					end
				end
				S_INS_CHK: begin
					if (!rd_occ_q) begin
						live_q       <= live_q + 1'b1;
						stat_q       <= ST_OK;
						probe_q      <= step_q;
					end else begin
						if (swap) begin
							req_q   <= rd_q;
							cdist_q <= {1'b0, their} + 1'b1;
						end else begin
							cdist_q <= cdist_q + 1'b1;
						end
						idx_q  <= nxt_idx;
						step_q <= step_q + 1'b1;
					end
				end
				S_DEL_CHK: begin
					if (del_end) begin
						if (live_q != '0) begin
							live_q <= live_q - 1'b1;
						end
					end else begin
						hole_q <= idx_q;
						idx_q  <= nxt_idx;
						step_q <= step_q + 1'b1;
					end
				end
				S_DONE: done_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = stat_q;
	assign read_value   = rval_q;
	assign probe_length = probe_q;
	assign entry_count  = live_q;
endmodule

// ===== rtl/rhh_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Robin Hood hash table port checker
// Port-level properties of the core, bound into the core module.
// ---------------------------------------------------------------------------
module rhh_checker import rhh_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [1:0]       status,
	input logic [63:0]      read_value,
	input logic [CNT_W-1:0] entry_count
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept did not raise busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_rval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> read_value == '0) else $error("value on failure");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> $stable(entry_count)) else $error("count moved idle");
endmodule

bind robin_hood_hash_table_core rhh_checker u_rhh_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .read_value(read_value), .entry_count(entry_count)
);

// ===== tb/robin_hood_hash_table_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Robin Hood hash table core testbench
// Runs a table of directed operations, random phases over a small clustered
// key pool, then a fill to full capacity. Each result word is compared with
// a typed answer or a behavioral model of the table kept in the testbench.
// ---------------------------------------------------------------------------
module robin_hood_hash_table_core_test;
	import rhh_pkg::*;

	localparam int IDLE_LIMIT = 60000;
	localparam int POOL_N     = 48;

	typedef struct {
		func_t       f;
		logic [63:0] k;
		logic [63:0] h;
		logic [63:0] v;
	} op_t;

	typedef struct {
		status_t              st;
		logic [63:0]          rv;
		logic [PROBE_W-1:0]   pl;
		logic [CNT_W-1:0]     ec;
	} answer_t;

	// directed row: either an operation or a max_entries write
	typedef struct {
		bit          is_cfg;
		logic [10:0] cfg_val;
		op_t         op;
		bit          typed;
		answer_t     ans;
	} row_t;

	logic clk, arst_n;
	logic start, busy, done;
	logic [1:0] func;
	logic [63:0] key_in, key_hash, value_in;
	logic [1:0] status;
	logic [63:0] read_value;
	logic [PROBE_W-1:0] probe_length;
	logic [CNT_W-1:0] entry_count;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	robin_hood_hash_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .key_in(key_in), .key_hash(key_hash), .value_in(value_in),
		.done(done), .status(status), .read_value(read_value),
		.probe_length(probe_length), .entry_count(entry_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model of the table contents
	bit          occ [CAPACITY];
	logic [63:0] s_hash [CAPACITY];
	logic [63:0] s_key [CAPACITY];
	logic [63:0] s_val [CAPACITY];
	int unsigned live;
	int unsigned limit_entries;

	answer_t pending [$];
	int errors;
	int idle_cycles;
	int burst_left;
	logic [63:0] pool_k [POOL_N];
	logic [63:0] pool_h [POOL_N];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int unsigned home(logic [63:0] h);
		return h % CAPACITY;
	endfunction

	function automatic int unsigned probe_dist(int unsigned idx, logic [63:0] h);
		return (idx + CAPACITY - home(h)) % CAPACITY;
	endfunction

	// search for key/hash; returns hit and where, probes always set
	function automatic bit find_slot(logic [63:0] k, logic [63:0] h,
		output int unsigned where, output int unsigned probes);
		int unsigned idx;
		idx = home(h);
		probes = 0;
		where = 0;
		for (int unsigned i = 0; i < CAPACITY; i++) begin
			probes = i + 1;
			if (!occ[idx]) return 1'b0;
			if (s_hash[idx] == h && s_key[idx] == k) begin
				where = idx;
				return 1'b1;
			end
			if (probe_dist(idx, s_hash[idx]) < i) return 1'b0;
			idx = (idx + 1) % CAPACITY;
		end
		return 1'b0;
	endfunction

	// apply one operation to the model and give the answer it causes
	function automatic answer_t table_apply(op_t r);
		answer_t a;
		int unsigned where, probes, idx, their, cdist, hole, nxt;
		logic [63:0] ck, cv, ch, tk, tv, th;
		bit hit;
		a.st = ST_NOT_FOUND;
		a.rv = '0;
		probes = 0;
		case (r.f)
			FN_INSERT: begin
				hit = find_slot(r.k, r.h, where, probes);
				if (hit) a.st = ST_EXISTS;
				else if (live >= limit_entries || live >= CAPACITY) a.st = ST_FULL;
				else begin
					ck = r.k; cv = r.v; ch = r.h;
					cdist = 0;
					idx = home(r.h);
					for (int unsigned i = 0; i < CAPACITY; i++) begin
						if (!occ[idx]) begin
							occ[idx] = 1'b1;
							s_hash[idx] = ch; s_key[idx] = ck; s_val[idx] = cv;
							live++;
							probes = i + 1;
							a.st = ST_OK;
							break;
						end
						their = probe_dist(idx, s_hash[idx]);
						// swap with a richer resident and carry it on
						if (cdist > their) begin
							tk = s_key[idx]; tv = s_val[idx]; th = s_hash[idx];
							s_key[idx] = ck; s_val[idx] = cv; s_hash[idx] = ch;
							ck = tk; cv = tv; ch = th;
							cdist = their;
						end
						cdist++;
						idx = (idx + 1) % CAPACITY;
					end
				end
			end
			FN_LOOKUP: begin
				if (find_slot(r.k, r.h, where, probes)) begin
					a.st = ST_OK;
					a.rv = s_val[where];
				end
			end
			FN_REMOVE: begin
				if (find_slot(r.k, r.h, where, probes)) begin
					hole = where;
					nxt = (hole + 1) % CAPACITY;
					// shift displaced followers back by one slot
					for (int unsigned n = 1; n < CAPACITY; n++) begin
						if (!occ[nxt] || probe_dist(nxt, s_hash[nxt]) == 0) break;
						s_hash[hole] = s_hash[nxt];
						s_key[hole] = s_key[nxt];
						s_val[hole] = s_val[nxt];
						hole = nxt;
						nxt = (nxt + 1) % CAPACITY;
					end
					occ[hole] = 1'b0;
					if (live > 0) live--;
					a.st = ST_OK;
				end
			end
			default: ;
		endcase
		a.pl = probes[PROBE_W-1:0];
		a.ec = live[CNT_W-1:0];
		return a;
	endfunction

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Present one word: idle between bursts, hold start until accepted.
	// Returns right after the accepting edge with start still high.
	task automatic issue(op_t r, bit typed, answer_t ans);
		answer_t a;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		start <= 1'b1;
		func <= r.f;
		key_in <= r.k;
		key_hash <= r.h;
		value_in <= r.v;
		do @(posedge clk); while (busy);
		a = table_apply(r);
		pending.push_back(typed ? ans : a);
	endtask

	// Drop start, drain all answers, then write max_entries over APB.
	task automatic write_limit(logic [10:0] val);
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending.size() != 0 || busy);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {21'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		limit_entries = val;
		@(posedge clk);
	endtask

	function automatic op_t mk(func_t f, logic [63:0] k, logic [63:0] h, logic [63:0] v);
		op_t r;
		r.f = f; r.k = k; r.h = h; r.v = v;
		return r;
	endfunction

	function automatic op_t random_op();
		op_t r;
		int unsigned sel, p;
		sel = $urandom_range(0, 99);
		p = $urandom_range(0, POOL_N - 1);
		r.v = {$urandom, $urandom};
		if (sel < 5) begin
			// noise: fully random key and hash, any code
			r.f = func_t'($urandom_range(0, 3));
			r.k = {$urandom, $urandom};
			r.h = {$urandom, $urandom};
			return r;
		end
		r.k = pool_k[p];
		r.h = pool_h[p];
		if (sel < 48) r.f = FN_INSERT;
		else if (sel < 80) r.f = FN_LOOKUP;
		else if (sel < 98) r.f = FN_REMOVE;
		else r.f = FN_NONE;
		return r;
	endfunction

	// check each result word against the oldest expected answer
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (pending.size() == 0) report("result with nothing expected");
			else begin
				e = pending.pop_front();
				if (status !== e.st)
					report($sformatf("status %0d, want %0d", status, e.st));
				if (read_value !== e.rv)
					report($sformatf("read_value %h, want %h", read_value, e.rv));
				if (probe_length !== e.pl)
					report($sformatf("probe_length %0d, want %0d", probe_length, e.pl));
				if (entry_count !== e.ec)
					report($sformatf("entry_count %0d, want %0d", entry_count, e.ec));
			end
		end
	end

	// watchdog: cycles in which no word moves on either side
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("robin_hood_hash_table_core_test NOT OK");
			$finish;
		end
	end

	initial begin
		row_t rows [$];
		row_t rw;
		answer_t none;
		logic [63:0] ones;
		ones = '1;
		none = '{ST_OK, 64'd0, '0, '0};
		errors = 0;
		idle_cycles = 0;
		burst_left = 0;
		live = 0;
		limit_entries = MAXE_RESET;
		for (int i = 0; i < CAPACITY; i++) occ[i] = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_NONE;
		key_in = '0;
		key_hash = '0;
		value_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// clustered pool: homes near the wrap point, some keys share hashes
		for (int i = 0; i < POOL_N; i++) begin
			pool_k[i] = (i % 8 == 7) ? pool_k[i - 1] : {$urandom, $urandom};
			pool_h[i] = {$urandom, $urandom};
			pool_h[i][9:0] = 10'((1016 + $urandom_range(0, 15)) % CAPACITY);
			if (i % 8 == 3) pool_h[i] = pool_h[i - 1];
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; typed answers only where obvious
		rows.push_back('{0, 0, mk(FN_LOOKUP, 0, 0, 0), 1, '{ST_NOT_FOUND, 0, 1, 0}});
		rows.push_back('{0, 0, mk(FN_REMOVE, ones, ones, ones), 1,
			'{ST_NOT_FOUND, 0, 1, 0}});
		rows.push_back('{0, 0, mk(FN_NONE, 5, 5, 5), 1, '{ST_NOT_FOUND, 0, 0, 0}});
		rows.push_back('{0, 0, mk(FN_INSERT, 0, 0, 0), 1, '{ST_OK, 0, 1, 1}});
		rows.push_back('{0, 0, mk(FN_INSERT, 0, 0, 9), 1, '{ST_EXISTS, 0, 1, 1}});
		rows.push_back('{0, 0, mk(FN_INSERT, ones, ones, ones), 1, '{ST_OK, 0, 1, 2}});
		rows.push_back('{0, 0, mk(FN_LOOKUP, ones, ones, 0), 1, '{ST_OK, ones, 1, 2}});
		// same key, other hash; same hash, other key: both are new entries
		rows.push_back('{0, 0, mk(FN_INSERT, ones, 64'h1023, 7), 0, none});
		rows.push_back('{0, 0, mk(FN_INSERT, 1, ones, 8), 0, none});
		rows.push_back('{0, 0, mk(FN_INSERT, 2, 64'h3ff, 11), 0, none});
		rows.push_back('{0, 0, mk(FN_LOOKUP, 2, 64'h3ff, 0), 0, none});
		rows.push_back('{0, 0, mk(FN_LOOKUP, 3, 64'h3ff, 0), 0, none});
		rows.push_back('{0, 0, mk(FN_REMOVE, ones, ones, 0), 0, none});
		rows.push_back('{0, 0, mk(FN_LOOKUP, 2, 64'h3ff, 0), 0, none});
		rows.push_back('{0, 0, mk(FN_LOOKUP, 0, 0, 0), 0, none});
		rows.push_back('{1, 11'd1, mk(FN_NONE, 0, 0, 0), 0, none});
		rows.push_back('{0, 0, mk(FN_INSERT, 77, 77, 77), 0, none});
		rows.push_back('{0, 0, mk(FN_INSERT, 0, 0, 1), 0, none});
		rows.push_back('{1, 11'd1024, mk(FN_NONE, 0, 0, 0), 0, none});
		rows.push_back('{0, 0, mk(FN_INSERT, 77, 77, 77), 0, none});
		rows.push_back('{0, 0, mk(FN_REMOVE, 77, 77, 0), 0, none});
		rows.push_back('{0, 0, mk(FN_REMOVE, 77, 77, 0), 0, none});
		foreach (rows[i]) begin
			rw = rows[i];
			if (rw.is_cfg) write_limit(rw.cfg_val);
			else issue(rw.op, rw.typed, rw.ans);
		end

		// random phases under several load limits
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_limit(11'd1024);
				1: write_limit(11'd5);
				2: write_limit(11'd1);
				default: write_limit(11'($urandom_range(1, 1024)));
			endcase
			repeat (210) issue(random_op(), 0, none);
		end

		// fill to full capacity, a few past it, then pool traffic on a full table
		write_limit(11'd1024);
		for (int i = 0; i < 2 * CAPACITY && live < CAPACITY; i++)
			issue(mk(FN_INSERT, {32'hf00d0000, i}, {$urandom, 22'd0, 10'(i)},
				{$urandom, $urandom}), 0, none);
		for (int i = 0; i < 4; i++)
			issue(mk(FN_INSERT, {32'hfeed0000, i}, {$urandom, $urandom},
				{$urandom, $urandom}), 0, none);
		repeat (16) issue(random_op(), 0, none);

		start <= 1'b0;
		do @(posedge clk); while (pending.size() != 0);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("robin_hood_hash_table_core_test OK");
		else $display("robin_hood_hash_table_core_test NOT OK");
		$finish;
	end
endmodule
